FILE: rtl/i2cebm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2cebm_pkg;

  // Sequence step codes
  localparam logic [5:0] STEP_IDLE  = 6'd0;
  localparam logic [5:0] STEP_FIRST = 6'd1;
  localparam logic [5:0] STEP_WAIT  = 6'd63;

  // Program lengths in phases
  localparam logic [5:0] WR_LEN = 6'd17;
  localparam logic [5:0] RD_LEN = 6'd24;

  localparam logic [7:0] MSB_MASK = 8'h80;

  // Operation codes on the item channel
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDR = 2'd0;
  localparam logic [1:0] REG_PHASE_TICKS = 2'd1;
  localparam logic [1:0] REG_WRITE_WAIT  = 2'd2;

  localparam logic [7:0]  DEVICE_ADDR_RESET = 8'd160;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd1;
  localparam logic [19:0] WRITE_WAIT_RESET  = 20'd10000;

  // Bus phase kinds
  typedef enum logic [3:0] {
    KIND_SA,
    KIND_SB,
    KIND_SC,
    KIND_TXH,
    KIND_TXL,
    KIND_AKH,
    KIND_AKL,
    KIND_RXH,
    KIND_RXL,
    KIND_NKH,
    KIND_NKL,
    KIND_PA,
    KIND_PB
  } phase_kind_t;

  // Source of a transmitted byte
  typedef enum logic [1:0] {
    SRC_DEV,
    SRC_ADDR,
    SRC_DATA,
    SRC_DEVR
  } tx_src_t;

  typedef struct packed {
    phase_kind_t kind;
    tx_src_t     src;
  } phase_row_t;

  // Look up one phase of the write or read program
  function automatic phase_row_t phase_row(input logic read_sel, input logic [4:0] idx);
    phase_row_t r;
    r.kind = KIND_SA;
    r.src  = SRC_DEV;
    if (!read_sel) begin
      unique case (idx)
        5'd0:  r.kind = KIND_SA;
        5'd1:  r.kind = KIND_SB;
        5'd2:  r.kind = KIND_SC;
        5'd3:  begin r.kind = KIND_TXH; r.src = SRC_DEV; end
        5'd4:  begin r.kind = KIND_TXL; r.src = SRC_DEV; end
        5'd5:  r.kind = KIND_AKH;
        5'd6:  r.kind = KIND_AKL;
        5'd7:  begin r.kind = KIND_TXH; r.src = SRC_ADDR; end
        5'd8:  begin r.kind = KIND_TXL; r.src = SRC_ADDR; end
        5'd9:  r.kind = KIND_AKH;
        5'd10: r.kind = KIND_AKL;
        5'd11: begin r.kind = KIND_TXH; r.src = SRC_DATA; end
        5'd12: begin r.kind = KIND_TXL; r.src = SRC_DATA; end
        5'd13: r.kind = KIND_AKH;
        5'd14: r.kind = KIND_AKL;
        5'd15: r.kind = KIND_PA;
        5'd16: r.kind = KIND_PB;
        default: r.kind = KIND_SA;
      endcase
    end else begin
      unique case (idx)
        5'd0:  r.kind = KIND_SA;
        5'd1:  r.kind = KIND_SB;
        5'd2:  r.kind = KIND_SC;
        5'd3:  begin r.kind = KIND_TXH; r.src = SRC_DEV; end
        5'd4:  begin r.kind = KIND_TXL; r.src = SRC_DEV; end
        5'd5:  r.kind = KIND_AKH;
        5'd6:  r.kind = KIND_AKL;
        5'd7:  begin r.kind = KIND_TXH; r.src = SRC_ADDR; end
        5'd8:  begin r.kind = KIND_TXL; r.src = SRC_ADDR; end
        5'd9:  r.kind = KIND_AKH;
        5'd10: r.kind = KIND_AKL;
        5'd11: r.kind = KIND_SA;
        5'd12: r.kind = KIND_SB;
        5'd13: r.kind = KIND_SC;
        5'd14: begin r.kind = KIND_TXH; r.src = SRC_DEVR; end
        5'd15: begin r.kind = KIND_TXL; r.src = SRC_DEVR; end
        5'd16: r.kind = KIND_AKH;
        5'd17: r.kind = KIND_AKL;
        5'd18: r.kind = KIND_RXH;
        5'd19: r.kind = KIND_RXL;
        5'd20: r.kind = KIND_NKH;
        5'd21: r.kind = KIND_NKL;
        5'd22: r.kind = KIND_PA;
        5'd23: r.kind = KIND_PB;
        default: r.kind = KIND_SA;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/i2c_eeprom_byte_master_core.sv
// I2C master for a single EEPROM byte write or random byte read.
// Item channel (item_valid / item_stall): each word is one bus tick carrying
// an opcode (plain tick, start write, start read), the word address, the
// write data and the sampled SDA level. A start is taken only when idle.
// Result channel (result_valid / result_stall): one word per item with the
// SCL level, the SDA pull-down, busy, a done pulse, the last read byte and
// the NACK flag.
// Configuration channel (cfg_valid / cfg_ready): cfg_ready is always high;
// index 0 device byte, 1 ticks per bus phase, 2 write-cycle wait ticks.
// The result word is registered on acceptance; one item is taken every
// cycle while item_stall is low, set by the combinational next-state
// logic of the phase sequencer. The result register lets a new word in
// while the previous result is taken; if the receiver stalls with a
// result pending, item_stall rises and the sequencer holds.
// Synchronous reset returns the sequencer to idle, clears the counters and
// flags, and loads the register defaults (160, 1, 10000).
`timescale 1ns / 1ps
`default_nettype none

module i2c_eeprom_byte_master_core
  import i2cebm_pkg::*;
#(
  parameter int WAIT_COUNTER_WIDTH = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  mem_addr,
  input  wire logic [7:0]  write_data,
  input  wire logic        sda_in,
  // result channel
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             scl_level,
  output logic             sda_pull_low,
  output logic             busy_res,
  output logic             done_res,
  output logic [7:0]       read_byte,
  output logic             nack_seen,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  localparam int WCW = WAIT_COUNTER_WIDTH;
  localparam logic [31:0] WAIT_MASK = 32'((64'd1 << WCW) - 64'd1);

  // Configuration registers
  logic [7:0]  device_addr_byte;
  logic [15:0] phase_ticks;
  logic [19:0] write_wait_ticks;

  // Sequencer state
  logic [5:0]     sequence_step, sequence_step_next;
  logic [15:0]    phase_counter, phase_counter_next;
  logic [2:0]     bit_counter, bit_counter_next;
  logic [7:0]     shift_byte, shift_byte_next;
  logic [7:0]     latched_addr, latched_addr_next;
  logic [7:0]     latched_data, latched_data_next;
  logic [7:0]     received_byte, received_byte_next;
  logic           read_mode, read_mode_next;
  logic           nack_flag, nack_flag_next;
  logic [WCW-1:0] wait_counter, wait_counter_next;

  logic accept;
  logic scl_next, pull_next, busy_next, done_next;

  assign cfg_ready  = 1'b1;
  assign item_stall = result_valid & result_stall;
  assign accept     = item_valid & ~item_stall;

  // Work out the next state and the result of one tick
  always_comb begin
    logic        start;
    logic [31:0] wait_wide;
    logic [31:0] target_wide;
    logic [WCW-1:0] target;
    logic [WCW-1:0] wait_inc;
    logic [5:0]  prog_len;
    logic [4:0]  row_idx;
    phase_row_t  row;
    logic [15:0] lim;
    logic [15:0] pc_inc;
    logic [7:0]  tx;
    logic [7:0]  shifted;

    start = (sequence_step == STEP_IDLE) && (opcode == OP_WRITE || opcode == OP_READ);

    wait_wide   = 32'(write_wait_ticks);
    target_wide = (wait_wide > WAIT_MASK) ? WAIT_MASK : wait_wide;
    target      = target_wide[WCW-1:0];

    // take the operands on a start
    sequence_step_next = sequence_step;
    phase_counter_next = phase_counter;
    bit_counter_next   = bit_counter;
    shift_byte_next    = shift_byte;
    latched_addr_next  = latched_addr;
    latched_data_next  = latched_data;
    received_byte_next = received_byte;
    read_mode_next     = read_mode;
    nack_flag_next     = nack_flag;
    wait_counter_next  = wait_counter;
    if (start) begin
      latched_addr_next = mem_addr;
      if (opcode == OP_WRITE) begin
        latched_data_next = write_data;
      end
      read_mode_next     = (opcode == OP_READ);
      nack_flag_next     = 1'b0;
      sequence_step_next = STEP_FIRST;
      phase_counter_next = '0;
      bit_counter_next   = '0;
      shift_byte_next    = '0;
      wait_counter_next  = '0;
    end

    scl_next  = 1'b1;
    pull_next = 1'b0;
    busy_next = 1'b0;
    done_next = 1'b0;

    prog_len = read_mode_next ? RD_LEN : WR_LEN;
    row_idx  = 5'(sequence_step_next - 6'd1);
    row      = phase_row(read_mode_next, row_idx);
    lim      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    pc_inc   = phase_counter_next + 16'd1;
    wait_inc = wait_counter_next + WCW'(1);
    shifted  = {shift_byte_next[6:0], sda_in};

    unique case (row.src)
      SRC_DEV:  tx = device_addr_byte;
      SRC_ADDR: tx = latched_addr_next;
      SRC_DATA: tx = latched_data_next;
      SRC_DEVR: tx = device_addr_byte | 8'd1;
      default:  tx = device_addr_byte;
    endcase

    priority if (sequence_step_next == STEP_WAIT) begin
      // hold busy through the write cycle
      busy_next         = 1'b1;
      wait_counter_next = wait_inc;
      if (wait_inc >= target) begin
        done_next          = 1'b1;
        sequence_step_next = STEP_IDLE;
      end
    end else if (sequence_step_next == STEP_IDLE) begin
      busy_next = 1'b0;
    end else if (sequence_step_next > prog_len) begin
      // drop back to idle from a step outside the program
      sequence_step_next = STEP_IDLE;
    end else begin
      busy_next = 1'b1;
      unique case (row.kind)
        KIND_SA:  begin scl_next = 1'b1; pull_next = 1'b0; end
        KIND_SB:  begin scl_next = 1'b1; pull_next = 1'b1; end
        KIND_SC:  begin scl_next = 1'b0; pull_next = 1'b1; end
        KIND_TXH, KIND_TXL: begin
          scl_next  = (row.kind == KIND_TXH);
          pull_next = ((tx & (MSB_MASK >> bit_counter_next)) == 8'd0);
        end
        KIND_PA:  begin scl_next = 1'b1; pull_next = 1'b1; end
        KIND_PB:  begin scl_next = 1'b1; pull_next = 1'b0; end
        KIND_AKH, KIND_RXH, KIND_NKH: begin scl_next = 1'b1; pull_next = 1'b0; end
        default:  begin scl_next = 1'b0; pull_next = 1'b0; end
      endcase

      phase_counter_next = pc_inc;
      if (pc_inc >= lim) begin
        phase_counter_next = '0;
        // sample SDA at the end of an SCL-high slot
        if (row.kind == KIND_AKH) begin
          if (sda_in) begin
            nack_flag_next = 1'b1;
          end
        end else if (row.kind == KIND_RXH) begin
          shift_byte_next = shifted;
          if (bit_counter_next == 3'd7) begin
            received_byte_next = shifted;
          end
        end

        // advance the program
        if (row.kind == KIND_TXL || row.kind == KIND_RXL) begin
          if (bit_counter_next != 3'd7) begin
            bit_counter_next   = bit_counter_next + 3'd1;
            sequence_step_next = sequence_step_next - 6'd1;
          end else begin
            bit_counter_next   = '0;
            sequence_step_next = sequence_step_next + 6'd1;
          end
        end else if (row.kind == KIND_PB) begin
          if (!read_mode_next && target != '0) begin
            sequence_step_next = STEP_WAIT;
            wait_counter_next  = '0;
          end else begin
            done_next          = 1'b1;
            sequence_step_next = STEP_IDLE;
          end
        end else begin
          sequence_step_next = sequence_step_next + 6'd1;
        end
      end
    end
  end

  // Hold configuration, sequencer state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      device_addr_byte <= DEVICE_ADDR_RESET;
      phase_ticks      <= PHASE_TICKS_RESET;
      write_wait_ticks <= WRITE_WAIT_RESET;
      sequence_step    <= STEP_IDLE;
      phase_counter    <= '0;
      bit_counter      <= '0;
      shift_byte       <= '0;
      latched_addr     <= '0;
      latched_data     <= '0;
      received_byte    <= '0;
      read_mode        <= 1'b0;
      nack_flag        <= 1'b0;
      wait_counter     <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEVICE_ADDR: device_addr_byte <= cfg_data[7:0];
          REG_PHASE_TICKS: phase_ticks      <= cfg_data[15:0];
          REG_WRITE_WAIT:  write_wait_ticks <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        sequence_step <= sequence_step_next;
        phase_counter <= phase_counter_next;
        bit_counter   <= bit_counter_next;
        shift_byte    <= shift_byte_next;
        latched_addr  <= latched_addr_next;
        latched_data  <= latched_data_next;
        received_byte <= received_byte_next;
        read_mode     <= read_mode_next;
        nack_flag     <= nack_flag_next;
        wait_counter  <= wait_counter_next;
        result_valid  <= 1'b1;
      end else if (!result_stall) begin
        result_valid  <= 1'b0;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      scl_level    <= scl_next;
      sda_pull_low <= pull_next;
      busy_res     <= busy_next;
      done_res     <= done_next;
      read_byte    <= received_byte_next;
      nack_seen    <= nack_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: tb/i2cebm_checker.sv
`timescale 1ns / 1ps

module i2cebm_checker
  import i2cebm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // item channel
  input  wire logic        item_valid,
  input  wire logic        item_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  mem_addr,
  input  wire logic [7:0]  write_data,
  input  wire logic        sda_in,
  // result channel
  input  wire logic        result_valid,
  input  wire logic        result_stall,
  input  wire logic        scl_level,
  input  wire logic        sda_pull_low,
  input  wire logic        busy_res,
  input  wire logic        done_res,
  input  wire logic [7:0]  read_byte,
  input  wire logic        nack_seen,
  // configuration channel
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  // towards the testbench top
  output int               mismatches,
  output int               outstanding
);

  typedef struct packed {
    logic       scl;
    logic       pull;
    logic       busy;
    logic       done;
    logic [7:0] rbyte;
    logic       nack;
  } bus_word_t;

  // Shadow of the configuration registers
  logic [7:0]  dev_byte;
  logic [15:0] ticks_per_phase;
  logic [19:0] wait_target;

  // Shadow of the bus sequencer
  logic [5:0]  step;
  logic [15:0] phase_cnt;
  logic [2:0]  bit_idx;
  logic [7:0]  shift_q;
  logic [7:0]  addr_q;
  logic [7:0]  data_q;
  logic [7:0]  rx_q;
  logic        read_q;
  logic        nack_q;
  logic [19:0] wait_cnt;

  bus_word_t bus_words_due[$];
  int        words_checked;

  // Print a failure line and count it
  task automatic report_error(input string msg);
    $display("%0t ns: word %0d: %s", $time, words_checked, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) report_error($sformatf("%s expected %0h, got %0h", name, want, got));
  endtask

  // Advance the bus sequencer by one tick and work out the word it gives
  task automatic advance_bus(input logic [1:0] op, input logic [7:0] addr,
                             input logic [7:0] data, input logic sda,
                             output bus_word_t w);
    phase_kind_t kind;
    tx_src_t     src;
    logic [7:0]  tx;
    logic [15:0] lim;
    logic [5:0]  len;
    int          grp;
    int          pos;
    w = '0;
    w.scl = 1'b1;
    // take a start only from idle
    if (step == STEP_IDLE && (op == OP_WRITE || op == OP_READ)) begin
      addr_q = addr;
      if (op == OP_WRITE) data_q = data;
      read_q    = (op == OP_READ);
      nack_q    = 1'b0;
      step      = STEP_FIRST;
      phase_cnt = '0;
      bit_idx   = '0;
      shift_q   = '0;
      wait_cnt  = '0;
    end
    if (step == STEP_WAIT) begin
      // count out the EEPROM write cycle
      w.busy   = 1'b1;
      wait_cnt = wait_cnt + 20'd1;
      if (wait_cnt >= wait_target) begin
        w.done = 1'b1;
        step   = STEP_IDLE;
      end
    end else if (step != STEP_IDLE) begin
      len = read_q ? RD_LEN : WR_LEN;
      if (step > len) begin
        step = STEP_IDLE;
      end else begin
        // locate the phase: start group, byte group or tail
        src = SRC_DEV;
        if (step <= 6'd3) begin
          grp = 0;
          pos = step - 1;
        end else if (!read_q && step <= 6'd15) begin
          grp = 1;
          pos = (step - 4) % 4;
          src = (step <= 6'd7) ? SRC_DEV : (step <= 6'd11) ? SRC_ADDR : SRC_DATA;
        end else if (!read_q) begin
          grp = 2;
          pos = step - 12;
        end else if (step <= 6'd11) begin
          grp = 1;
          pos = (step - 4) % 4;
          src = (step <= 6'd7) ? SRC_DEV : SRC_ADDR;
        end else if (step <= 6'd14) begin
          grp = 0;
          pos = step - 12;
        end else if (step <= 6'd18) begin
          grp = 1;
          pos = step - 15;
          src = SRC_DEVR;
        end else begin
          grp = 2;
          pos = step - 19;
        end
        case (grp)
          0: kind = (pos == 0) ? KIND_SA : (pos == 1) ? KIND_SB : KIND_SC;
          1: kind = (pos == 0) ? KIND_TXH : (pos == 1) ? KIND_TXL :
                    (pos == 2) ? KIND_AKH : KIND_AKL;
          default: begin
            case (pos)
              0: kind = KIND_RXH;
              1: kind = KIND_RXL;
              2: kind = KIND_NKH;
              3: kind = KIND_NKL;
              4: kind = KIND_PA;
              default: kind = KIND_PB;
            endcase
          end
        endcase
        case (src)
          SRC_DEV:  tx = dev_byte;
          SRC_ADDR: tx = addr_q;
          SRC_DATA: tx = data_q;
          default:  tx = dev_byte | 8'h01;
        endcase
        // drive the lines for this phase
        w.busy = 1'b1;
        case (kind)
          KIND_SA, KIND_PB, KIND_AKH, KIND_RXH, KIND_NKH: begin
            w.scl  = 1'b1;
            w.pull = 1'b0;
          end
          KIND_SB, KIND_PA: begin
            w.scl  = 1'b1;
            w.pull = 1'b1;
          end
          KIND_SC: begin
            w.scl  = 1'b0;
            w.pull = 1'b1;
          end
          KIND_TXH: begin
            w.scl  = 1'b1;
            w.pull = ~tx[7 - bit_idx];
          end
          KIND_TXL: begin
            w.scl  = 1'b0;
            w.pull = ~tx[7 - bit_idx];
          end
          default: begin
            w.scl  = 1'b0;
            w.pull = 1'b0;
          end
        endcase
        // end of phase: sample SDA and move on
        lim       = (ticks_per_phase == 16'd0) ? 16'd1 : ticks_per_phase;
        phase_cnt = phase_cnt + 16'd1;
        if (phase_cnt >= lim) begin
          phase_cnt = '0;
          if (kind == KIND_AKH && sda) nack_q = 1'b1;
          if (kind == KIND_RXH) begin
            shift_q = {shift_q[6:0], sda};
            if (bit_idx == 3'd7) rx_q = shift_q;
          end
          if (kind == KIND_TXL || kind == KIND_RXL) begin
            if (bit_idx < 3'd7) begin
              bit_idx = bit_idx + 3'd1;
              step    = step - 6'd1;
            end else begin
              bit_idx = '0;
              step    = step + 6'd1;
            end
          end else if (kind == KIND_PB) begin
            if (!read_q && wait_target != 20'd0) begin
              step     = STEP_WAIT;
              wait_cnt = '0;
            end else begin
              w.done = 1'b1;
              step   = STEP_IDLE;
            end
          end else begin
            step = step + 6'd1;
          end
        end
      end
    end
    w.rbyte = rx_q;
    w.nack  = nack_q;
  endtask

  always @(posedge clk) begin : track
    bus_word_t due;
    bus_word_t seen;
    if (rst) begin
      dev_byte        = DEVICE_ADDR_RESET;
      ticks_per_phase = PHASE_TICKS_RESET;
      wait_target     = WRITE_WAIT_RESET;
      step            = STEP_IDLE;
      phase_cnt       = '0;
      bit_idx         = '0;
      shift_q         = '0;
      addr_q          = '0;
      data_q          = '0;
      rx_q            = '0;
      read_q          = 1'b0;
      nack_q          = 1'b0;
      wait_cnt        = '0;
      words_checked   = 0;
      mismatches      = 0;
      bus_words_due.delete();
    end else begin
      // check a delivered word against the oldest prediction
      if (result_valid && !result_stall) begin
        seen = {scl_level, sda_pull_low, busy_res, done_res, read_byte, nack_seen};
        if (bus_words_due.size() == 0) begin
          report_error("result word with no item outstanding");
        end else begin
          due = bus_words_due.pop_front();
          compare_field("scl_level", 8'(due.scl), 8'(seen.scl));
          compare_field("sda_pull_low", 8'(due.pull), 8'(seen.pull));
          compare_field("busy_res", 8'(due.busy), 8'(seen.busy));
          compare_field("done_res", 8'(due.done), 8'(seen.done));
          compare_field("read_byte", due.rbyte, seen.rbyte);
          compare_field("nack_seen", 8'(due.nack), 8'(seen.nack));
        end
        words_checked++;
      end
      // predict the word for an accepted tick
      if (item_valid && !item_stall) begin
        advance_bus(opcode, mem_addr, write_data, sda_in, due);
        bus_words_due.push_back(due);
      end
      // register writes act from the next tick on
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEVICE_ADDR: dev_byte = cfg_data[7:0];
          REG_PHASE_TICKS: ticks_per_phase = cfg_data[15:0];
          REG_WRITE_WAIT:  wait_target = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = bus_words_due.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import i2cebm_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;

  // SDA behaviour of the simulated EEPROM during one transfer
  localparam int SDA_NOISY  = 0;
  localparam int SDA_ACKING = 1;
  localparam int SDA_LOW    = 2;
  localparam int SDA_HIGH   = 3;

  localparam int STALL_PCT      = 12;
  localparam int HOLD_CYCLES    = 150;
  localparam int HOLD_AT        = 400;
  localparam int QUIET_FROM     = 900;
  localparam int QUIET_TO       = 1200;
  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic [1:0]  opcode       = OP_TICK;
  logic [7:0]  mem_addr     = '0;
  logic [7:0]  write_data   = '0;
  logic        sda_in       = 1'b1;
  logic        result_stall = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [1:0]  cfg_index    = REG_DEVICE_ADDR;
  logic [19:0] cfg_data     = '0;

  logic        item_stall;
  logic        result_valid;
  logic        scl_level;
  logic        sda_pull_low;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  read_byte;
  logic        nack_seen;
  logic        cfg_ready;

  int mismatches;
  int outstanding;

  int sent_count  = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;
  int idle_cycles = 0;
  int cur_ticks   = PHASE_TICKS_RESET;
  int cur_wait    = WRITE_WAIT_RESET;

  i2c_eeprom_byte_master_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .mem_addr     (mem_addr),
    .write_data   (write_data),
    .sda_in       (sda_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .scl_level    (scl_level),
    .sda_pull_low (sda_pull_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .read_byte    (read_byte),
    .nack_seen    (nack_seen),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  i2cebm_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .mem_addr     (mem_addr),
    .write_data   (write_data),
    .sda_in       (sda_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .scl_level    (scl_level),
    .sda_pull_low (sda_pull_low),
    .busy_res     (busy_res),
    .done_res     (done_res),
    .read_byte    (read_byte),
    .nack_seen    (nack_seen),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always #10 clk = ~clk;

  // Stretch with no idling on either side
  function automatic bit quiet_window();
    return sent_count >= QUIET_FROM && sent_count < QUIET_TO;
  endfunction

  // Receiver: random stalls, plus one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      result_stall <= !quiet_window() && $urandom_range(99) < STALL_PCT;
    end
  end

  // Watchdog: abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one tick word, with random gaps, and hold it until taken
  task automatic send_item(input logic [1:0] op, input logic [7:0] addr,
                           input logic [7:0] data, input logic sda);
    while (!quiet_window() && $urandom_range(99) < STALL_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    mem_addr   <= addr;
    write_data <= data;
    sda_in     <= sda;
    @(negedge clk);
    while (item_stall) @(negedge clk);
    @(posedge clk);
    sent_count++;
  endtask

  task automatic idle_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_item($urandom_range(1) ? OP_TICK : OP_SPARE, 8'($urandom), 8'($urandom),
                1'($urandom_range(1)));
  endtask

  // One whole transfer: the start tick, then ticks until the done pulse,
  // sprinkled with starts that must be ignored while busy
  task automatic run_transfer(input logic rd, input logic [7:0] addr,
                              input logic [7:0] data, input int style);
    int         lim;
    int         total;
    int         r;
    logic [1:0] op;
    logic       sda;
    lim   = (cur_ticks == 0) ? 1 : cur_ticks;
    total = rd ? 80 * lim : 59 * lim + cur_wait;
    for (int i = 0; i < total; i++) begin
      r = $urandom_range(99);
      if (i == 0) op = rd ? OP_READ : OP_WRITE;
      else if (r < 4) op = OP_WRITE;
      else if (r < 8) op = OP_READ;
      else if (r < 14) op = OP_SPARE;
      else op = OP_TICK;
      case (style)
        SDA_LOW:    sda = 1'b0;
        SDA_HIGH:   sda = 1'b1;
        SDA_ACKING: sda = ($urandom_range(15) == 0);
        default:    sda = 1'($urandom_range(1));
      endcase
      if (i == 0) send_item(op, addr, data, sda);
      else send_item(op, 8'($urandom), 8'($urandom), sda);
    end
  endtask

  task automatic random_traffic(input int n);
    int stop_at;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      if ($urandom_range(9) < 7)
        run_transfer(1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                     $urandom_range(1) ? SDA_NOISY : SDA_ACKING);
      else
        idle_ticks($urandom_range(1, 6));
    end
  endtask

  // Drop valid and wait for every predicted word to be delivered
  task automatic drain();
    item_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] dev, input logic [15:0] pt,
                              input logic [19:0] wt);
    drain();
    repeat (3) @(posedge clk);
    write_reg(REG_DEVICE_ADDR, {12'd0, dev});
    write_reg(REG_PHASE_TICKS, {4'd0, pt});
    write_reg(REG_WRITE_WAIT, wt);
    cfg_valid <= 1'b0;
    cur_ticks = int'(pt);
    cur_wait  = int'(wt);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset values: idle lines, then a read with the default device byte
    idle_ticks(4);
    run_transfer(1'b1, 8'h00, 8'h00, SDA_LOW);

    // single-tick phases, no write wait
    program_regs(8'hA0, 16'd1, 20'd0);
    run_transfer(1'b0, 8'h00, 8'hFF, SDA_LOW);
    run_transfer(1'b0, 8'hFF, 8'h00, SDA_HIGH);
    run_transfer(1'b1, 8'hFF, 8'h00, SDA_HIGH);
    run_transfer(1'b1, 8'h5A, 8'hA5, SDA_NOISY);
    run_transfer(1'b0, 8'hA5, 8'h5A, SDA_ACKING);
    idle_ticks(6);
    random_traffic(200);

    // top device byte, two-tick phases, short wait
    program_regs(8'hFE, 16'd2, 20'd7);
    random_traffic(150);

    // zero device byte, zero phase length taken as one, one-tick wait
    program_regs(8'h00, 16'd0, 20'd1);
    random_traffic(150);

    // longer phases and a longer write wait
    program_regs(8'($urandom_range(254)), 16'd3, 20'd25);
    run_transfer(1'b0, 8'($urandom), 8'($urandom), SDA_ACKING);
    run_transfer(1'b1, 8'($urandom), 8'h00, SDA_NOISY);

    // largest phase and wait register values, idle ticks only
    program_regs(8'h55, 16'hFFFF, 20'hFFFFF);
    idle_ticks(30);

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/i2cebm_pkg.sv
rtl/i2c_eeprom_byte_master_core.sv
tb/i2cebm_checker.sv
tb/testbench.sv
